// ----- src/tcfc_pkg.sv -----
// Shared types, constants and helpers for the timecode to frame count core.
package tcfc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_RATE_NUM  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_DEN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_MODE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT0     = 3'd3;

    localparam logic [2:0] SRC_NONE = 3'd0;
    localparam logic [2:0] SRC_GOP  = 3'd4;

    localparam int TS_W          = 34;
    localparam int SECS_W        = 18;
    localparam int FRAMES_W      = 8;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = TS_W / DIV_PER_STAGE;

    typedef struct packed {
        logic                valid;
        logic                found;
        logic [2:0]          src;
        logic [FRAMES_W-1:0] ff;
        logic [15:0]         rem;
        logic [TS_W-1:0]     work;
    } div_word_t;

    function automatic logic [6:0] bcd_value(input logic [7:0] b);
        logic [6:0] v;
        if (b[3:0] > 4'd9 || b[7:4] > 4'd9)
        begin
            v = 7'd0;
        end
        else
        begin
            v = 7'(b[3:0]) + 7'(b[7:4]) * 7'd10;
        end
        return v;
    endfunction

endpackage

// ----- src/tcfc_if.sv -----
// Handshake channels for timecode words and frame count results.
interface tcfc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] s12m_count_word;
    logic [31:0] s12m_code1;
    logic [31:0] s12m_code2;
    logic [31:0] s12m_code3;
    logic [31:0] gop_code;
    logic        gop_present;

    modport source (output valid, s12m_count_word, s12m_code1, s12m_code2, s12m_code3,
                    gop_code, gop_present, input ready);
    modport sink (input valid, s12m_count_word, s12m_code1, s12m_code2, s12m_code3,
                  gop_code, gop_present, output ready);
endinterface

interface tcfc_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [2:0]  used_source;
    logic [33:0] frame_timestamp;

    modport source (output valid, found, used_source, frame_timestamp, input ready);
    modport sink (input valid, found, used_source, frame_timestamp, output ready);
endinterface

// ----- src/tcfc_div_stage.sv -----
// One pipelined stage of the restoring divider, two quotient bits per stage.
module tcfc_div_stage
    import tcfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic [15:0] den,
    input  div_word_t d_in,
    output div_word_t d_out
);

    div_word_t d_next;
    div_word_t d_reg;
    logic      valid_reg;

    always_comb
    begin
        logic [16:0] rem_sh;
        d_next = d_in;
        for (int k = 0; k < DIV_PER_STAGE; k++)
        begin
            rem_sh = {d_next.rem, d_next.work[TS_W-1]};
            d_next.work = {d_next.work[TS_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, den})
            begin
                rem_sh = rem_sh - {1'b0, den};
                d_next.work[0] = 1'b1;
            end
            d_next.rem = rem_sh[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    always_comb
    begin
        d_out       = d_reg;
        d_out.valid = valid_reg;
    end

endmodule

// ----- src/timecode_to_frame_count_core.sv -----
// Top level of the timecode to frame count core.
//
// in_chan carries one frame's S12M words and GOP timecode per word; out_chan
// returns one result word (found, used_source, frame_timestamp) for each.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
//
// Every stage advances together, so unless out_chan stalls a word enters each
// cycle and a result leaves each cycle: throughput is one word per cycle. The
// stages are source select, timecode decode, multiply by the rate numerator,
// 17 divider stages of two quotient bits each, and the output register.
//
// When out_chan stalls the whole pipeline holds and in_chan.ready drops;
// nothing is lost or repeated. Reset clears all stage valid bits and loads
// the register defaults: 30/1 fps, narrow frame field, slot 0 on the first
// S12M word and the other slots empty.
module timecode_to_frame_count_core
    import tcfc_pkg::*;
#(
    parameter int SOURCE_SLOTS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    tcfc_in_if.sink                in_chan,
    tcfc_out_if.source             out_chan
);

    logic [15:0] num_reg;
    logic [15:0] den_reg;
    logic        wide_reg;
    logic [2:0]  slot_reg [SOURCE_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= 16'd30;
            den_reg  <= 16'd1;
            wide_reg <= 1'b0;
            for (int i = 0; i < SOURCE_SLOTS; i++)
            begin
                slot_reg[i] <= (i == 0) ? 3'd1 : SRC_NONE;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_RATE_NUM)
            begin
                num_reg <= cfg_data;
            end
            if (cfg_index == REG_RATE_DEN)
            begin
                den_reg <= cfg_data;
            end
            if (cfg_index == REG_WIDE_MODE)
            begin
                wide_reg <= cfg_data[0];
            end
            for (int i = 0; i < SOURCE_SLOTS; i++)
            begin
                if (cfg_index == CFG_INDEX_W'(int'(REG_SLOT0) + i))
                begin
                    slot_reg[i] <= cfg_data[2:0];
                end
            end
        end
    end

    logic en;
    logic out_valid_reg;

    assign en            = !out_valid_reg || out_chan.ready;
    assign in_chan.ready = en;

    // source select
    logic        a_valid_reg, a_valid_next;
    logic        a_found_reg, a_found_next;
    logic [2:0]  a_src_reg, a_src_next;
    logic [31:0] a_code_reg, a_code_next;

    always_comb
    begin
        logic done;
        logic [31:0] avail;
        done         = 1'b0;
        a_found_next = 1'b0;
        a_src_next   = SRC_NONE;
        a_code_next  = 32'd0;
        a_valid_next = in_chan.valid;
        avail = (in_chan.s12m_count_word < 32'd3) ? in_chan.s12m_count_word : 32'd3;
        for (int i = 0; i < SOURCE_SLOTS; i++)
        begin
            if (!done)
            begin
                if (slot_reg[i] == SRC_NONE)
                begin
                    done = 1'b1;
                end
                else if (slot_reg[i] == SRC_GOP)
                begin
                    if (in_chan.gop_present)
                    begin
                        done         = 1'b1;
                        a_found_next = 1'b1;
                        a_src_next   = SRC_GOP;
                        a_code_next  = in_chan.gop_code;
                    end
                end
                else if (slot_reg[i] < SRC_GOP && 32'(slot_reg[i]) <= avail)
                begin
                    done         = 1'b1;
                    a_found_next = 1'b1;
                    a_src_next   = slot_reg[i];
                    case (slot_reg[i][1:0])
                        2'd1:    a_code_next = in_chan.s12m_code1;
                        2'd2:    a_code_next = in_chan.s12m_code2;
                        default: a_code_next = in_chan.s12m_code3;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_found_reg <= a_found_next;
            a_src_reg   <= a_src_next;
            a_code_reg  <= a_code_next;
        end
    end

    // timecode decode
    logic                b_valid_reg;
    logic                b_found_reg;
    logic [2:0]          b_src_reg;
    logic [SECS_W-1:0]   b_secs_reg, b_secs_next;
    logic [FRAMES_W-1:0] b_ff_reg, b_ff_next;
    logic                high_rate;
    logic                rate_50;

    assign high_rate = {5'd0, num_reg} > 21'(den_reg) * 21'd30;
    assign rate_50   = {5'd0, num_reg} == 21'(den_reg) * 21'd50;

    always_comb
    begin
        logic [6:0] hh;
        logic [6:0] mm;
        logic [6:0] ss;
        logic [6:0] ff;
        if (a_src_reg == SRC_GOP)
        begin
            hh = {2'd0, a_code_reg[23:19]};
            mm = {1'b0, a_code_reg[18:13]};
            ss = {1'b0, a_code_reg[11:6]};
            ff = {1'b0, a_code_reg[5:0]};
        end
        else
        begin
            hh = bcd_value({2'd0, a_code_reg[5:0]});
            mm = bcd_value({1'b0, a_code_reg[14:8]});
            ss = bcd_value({1'b0, a_code_reg[22:16]});
            ff = bcd_value(wide_reg ? {1'b0, a_code_reg[30:24]} : {2'd0, a_code_reg[29:24]});
        end
        b_ff_next = {1'b0, ff};
        if (a_src_reg != SRC_GOP && !wide_reg && high_rate)
        begin
            b_ff_next = {ff, rate_50 ? a_code_reg[7] : a_code_reg[23]};
        end
        b_secs_next = SECS_W'(hh) * SECS_W'(3600) + SECS_W'(mm) * SECS_W'(60) + SECS_W'(ss);
        if (!a_found_reg)
        begin
            b_secs_next = '0;
            b_ff_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_found_reg <= a_found_reg;
            b_src_reg   <= a_src_reg;
            b_secs_reg  <= b_secs_next;
            b_ff_reg    <= b_ff_next;
        end
    end

    // multiply by numerator
    div_word_t c_reg;
    div_word_t c_word;
    logic      c_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg.valid <= b_valid_reg;
            c_reg.found <= b_found_reg;
            c_reg.src   <= b_src_reg;
            c_reg.ff    <= b_ff_reg;
            c_reg.rem   <= '0;
            c_reg.work  <= TS_W'(b_secs_reg) * TS_W'(num_reg);
        end
    end

    always_comb
    begin
        c_word       = c_reg;
        c_word.valid = c_valid_reg;
    end

    // divide by denominator
    div_word_t div_w [DIV_STAGES+1];

    assign div_w[0] = c_word;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        tcfc_div_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .den   (den_reg),
            .d_in  (div_w[g]),
            .d_out (div_w[g+1])
        );
    end

    // output register
    div_word_t      last;
    logic           found_reg;
    logic [2:0]     src_reg;
    logic [TS_W-1:0] ts_reg, ts_next;

    assign last = div_w[DIV_STAGES];

    always_comb
    begin
        if (!last.found)
        begin
            ts_next = '0;
        end
        else if (den_reg == 16'd0)
        begin
            ts_next = '1;
        end
        else
        begin
            ts_next = last.work + TS_W'(last.ff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            found_reg <= last.found;
            src_reg   <= last.src;
            ts_reg    <= ts_next;
        end
    end

    assign out_chan.valid           = out_valid_reg;
    assign out_chan.found           = found_reg;
    assign out_chan.used_source     = src_reg;
    assign out_chan.frame_timestamp = ts_reg;

endmodule

// ----- src/tcfc_checker.sv -----
// Port-level checks for the timecode to frame count core, with its bind.
module tcfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        in_ready,
    input logic        found,
    input logic [2:0]  used_source,
    input logic [33:0] frame_timestamp
);

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> used_source == 3'd0 && frame_timestamp == 34'd0)
        else $error("empty result carries data");

    a_found_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> used_source != 3'd0 && used_source <= 3'd4)
        else $error("found result without a source");

    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_timestamp)
        && $stable(used_source))
        else $error("stalled result changed");

endmodule

bind timecode_to_frame_count_core tcfc_checker u_tcfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .in_ready        (in_chan.ready),
    .found           (out_chan.found),
    .used_source     (out_chan.used_source),
    .frame_timestamp (out_chan.frame_timestamp)
);
